// ===== sv/ptc_pkg.sv =====
// Package for the pressure and temperature compensation pipeline.
// Holds the payload structs, register indexes and fixed constants.
// No dependencies.
package ptc_pkg;

  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int TEMP_W    = 20;
  localparam int PRES_W    = 32;
  localparam int CFG_IDX_W = 3;

  // Temperatures in hundredths of a degree.
  localparam int TEMP_REF  = 2000;
  localparam int TEMP_VLOW = -1500;

  // The pipeline carries the first-order temperature as its offset from TEMP_REF.
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = TEMP_W'(TEMP_REF);
  localparam logic signed [17:0]       VLOW_DLT  = 18'(TEMP_VLOW - TEMP_REF);
  localparam logic signed [18:0]       VLOW_ADJ  = 19'(TEMP_REF - TEMP_VLOW);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_SENS   = 3'd0,
    REG_PRESS_OFFSET = 3'd1,
    REG_TCO_SENS     = 3'd2,
    REG_TCO_OFFSET   = 3'd3,
    REG_REF_TEMP     = 3'd4,
    REG_TCO_TEMP     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } ptc_in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_value;
  } ptc_out_t;

endpackage

// ===== sv/pressure_temp_compensation.sv =====
// Top level of the pressure and temperature compensation pipeline.
// Depends on ptc_pkg for the payload structs, register indexes and constants.
//
//   channel   signals                              direction  handshake
//   -------   ----------------------------------   ---------  ---------------------------
//   command   start, busy, operands                in         start & !busy
//   result    done, result                         out        done, one cycle, no stall
//   config    cfg_we, cfg_index, cfg_data           in         cfg_we, no wait, no readback
//
// A transaction can be started every clock cycle; busy stays low. Each result
// leaves in command order through the eleven register stages of the datapath
// and is shown for exactly one cycle with done high. The stages split the
// multiplies and the wide adds so that no stage chains two multiplies. The
// synchronous reset clears the coefficients and all stage valid bits, so no
// result is emitted for a transaction in flight at reset.
module pressure_temp_compensation
  import ptc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ptc_in_t              operands,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  output logic                 done,
  output ptc_out_t             result
);

  // Factory coefficients C1..C6.
  logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6;

  // Writes to an index past the last coefficient are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESS_SENS:   c1 <= cfg_data;
        REG_PRESS_OFFSET: c2 <= cfg_data;
        REG_TCO_SENS:     c3 <= cfg_data;
        REG_TCO_OFFSET:   c4 <= cfg_data;
        REG_REF_TEMP:     c5 <= cfg_data;
        REG_TCO_TEMP:     c6 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The pipeline never stalls, so a transaction is taken whenever start is high.
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // Valid bits, one per stage; stage 11 drives done.
  logic [10:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[9:0], accept};
    end
  end

  assign done = vld[10];

  // Stage 1: register the pressure reading and form dT = D2 - C5 * 256.
  logic [RAW_W-1:0]  d1_s1;
  logic signed [24:0] dt_s1, dt_next;

  assign dt_next = $signed({1'b0, operands.raw_temperature}) - $signed({1'b0, c5, 8'b0});

  // Stage 2: the four products of dT. Only bits 47..31 of dT squared are kept,
  // which is dT squared divided by 2^31 (the square is never negative).
  logic [RAW_W-1:0]   d1_s2;
  logic signed [40:0] p_off_s2, p_sens_s2, p_temp_s2;
  logic signed [40:0] p_off_next, p_sens_next, p_temp_next;
  logic signed [49:0] sq_full;
  logic [16:0]        t2_s2;

  assign p_off_next  = dt_s1 * $signed({1'b0, c4});
  assign p_sens_next = dt_s1 * $signed({1'b0, c3});
  assign p_temp_next = dt_s1 * $signed({1'b0, c6});
  assign sq_full     = dt_s1 * dt_s1;

  // Stage 3: divide by powers of two, truncating toward zero. A negative value
  // gets 2^k - 1 added before the arithmetic shift.
  logic [RAW_W-1:0]   d1_s3;
  logic signed [33:0] off_t_s3;
  logic signed [32:0] sens_t_s3;
  logic signed [17:0] dlt_s3;
  logic [16:0]        t2_s3;
  logic signed [40:0] off_rnd, sens_rnd, temp_rnd;

  assign off_rnd  = p_off_s2  + (p_off_s2[40]  ? 41'sd127     : 41'sd0);
  assign sens_rnd = p_sens_s2 + (p_sens_s2[40] ? 41'sd255     : 41'sd0);
  assign temp_rnd = p_temp_s2 + (p_temp_s2[40] ? 41'sd8388607 : 41'sd0);

  // Stage 4: first-order OFF and SENS, the squares for the second-order terms,
  // the low and very-low temperature flags and the final temperature.
  // dlt is the first-order temperature minus 2000.
  logic [RAW_W-1:0]    d1_s4;
  logic signed [34:0]  off1_s4, off1_next;
  logic signed [33:0]  sens1_s4, sens1_next;
  logic [33:0]         dsq_s4, losq_s4;
  logic                low_s4, vlow_s4;
  logic signed [TEMP_W-1:0] temp_s4, temp1, temp_next;
  logic signed [35:0]  dsq_full;
  logic signed [18:0]  lo;
  logic signed [37:0]  losq_full;
  logic                low_next, vlow_next;

  assign off1_next  = $signed({3'b0, c2, 16'b0}) + {off_t_s3[33], off_t_s3};
  assign sens1_next = $signed({3'b0, c1, 15'b0}) + {sens_t_s3[32], sens_t_s3};
  assign dsq_full   = dlt_s3 * dlt_s3;
  assign lo         = {dlt_s3[17], dlt_s3} + VLOW_ADJ;
  assign losq_full  = lo * lo;
  assign low_next   = dlt_s3[17];
  assign vlow_next  = dlt_s3 < VLOW_DLT;
  assign temp1      = TEMP_BASE + {{2{dlt_s3[17]}}, dlt_s3};
  assign temp_next  = low_next ? (temp1 - $signed({3'b0, t2_s3})) : temp1;

  // Stage 5: OFF2 = 3 * dlt^2, SENS2 = 7 * dlt^2 / 8, plus 2 * (TEMP + 1500)^2
  // when very cold. Both are zero above the low-temperature threshold.
  logic [RAW_W-1:0]   d1_s5;
  logic signed [34:0] off1_s5;
  logic signed [33:0] sens1_s5;
  logic [35:0]        off2_s5, sens2_s5, off2_next, sens2_next;
  logic signed [TEMP_W-1:0] temp_s5;
  logic [36:0]        sev;

  assign sev        = {dsq_s4, 3'b0} - {3'b0, dsq_s4};
  assign off2_next  = low_s4 ? ({2'b0, dsq_s4} + {1'b0, dsq_s4, 1'b0}) : 36'd0;
  assign sens2_next = (low_s4 ? {2'b0, sev[36:3]} : 36'd0)
                    + (vlow_s4 ? {1'b0, losq_s4, 1'b0} : 36'd0);

  // Stage 6: second-order OFF and SENS.
  logic [RAW_W-1:0]   d1_s6;
  logic signed [36:0] off_s6, sens_s6, off_next, sens_next;
  logic signed [TEMP_W-1:0] temp_s6;

  assign off_next  = {{2{off1_s5[34]}}, off1_s5} - $signed({1'b0, off2_s5});
  assign sens_next = {{3{sens1_s5[33]}}, sens1_s5} - $signed({1'b0, sens2_s5});

  // Stage 7: D1 * SENS as two partial products, split at bit 20 of SENS.
  logic [43:0]        pp_lo_s7, pp_lo_next;
  logic signed [40:0] pp_hi_s7, pp_hi_next;
  logic signed [36:0] off_s7;
  logic signed [TEMP_W-1:0] temp_s7;

  assign pp_lo_next = d1_s6 * sens_s6[19:0];
  assign pp_hi_next = $signed({1'b0, d1_s6}) * $signed(sens_s6[36:20]);

  // Stage 8: recombine the partial products.
  logic signed [60:0] prod_s8, prod_next;
  logic signed [36:0] off_s8;
  logic signed [TEMP_W-1:0] temp_s8;

  assign prod_next = $signed({pp_hi_s7, 20'b0}) + $signed({17'b0, pp_lo_s7});

  // Stage 9: D1 * SENS / 2^21.
  logic signed [39:0] a_s9;
  logic signed [36:0] off_s9;
  logic signed [TEMP_W-1:0] temp_s9;
  logic signed [60:0] prod_rnd;

  assign prod_rnd = prod_s8 + (prod_s8[60] ? 61'sd2097151 : 61'sd0);

  // Stage 10: subtract OFF.
  logic signed [40:0] b_s10, b_next;
  logic signed [TEMP_W-1:0] temp_s10;

  assign b_next = {a_s9[39], a_s9} - {{4{off_s9[36]}}, off_s9};

  // Stage 11: divide by 2^15 into the result register.
  logic signed [40:0] b_rnd;
  logic signed [25:0] pres_next;

  assign b_rnd     = b_s10 + (b_s10[40] ? 41'sd32767 : 41'sd0);
  assign pres_next = b_rnd[40:15];

  always_ff @(posedge clk) begin
    d1_s1     <= operands.raw_pressure;
    dt_s1     <= dt_next;

    d1_s2     <= d1_s1;
    p_off_s2  <= p_off_next;
    p_sens_s2 <= p_sens_next;
    p_temp_s2 <= p_temp_next;
    t2_s2     <= sq_full[47:31];

    d1_s3     <= d1_s2;
    off_t_s3  <= off_rnd[40:7];
    sens_t_s3 <= sens_rnd[40:8];
    dlt_s3    <= temp_rnd[40:23];
    t2_s3     <= t2_s2;

    d1_s4     <= d1_s3;
    off1_s4   <= off1_next;
    sens1_s4  <= sens1_next;
    dsq_s4    <= dsq_full[33:0];
    losq_s4   <= losq_full[33:0];
    low_s4    <= low_next;
    vlow_s4   <= vlow_next;
    temp_s4   <= temp_next;

    d1_s5     <= d1_s4;
    off1_s5   <= off1_s4;
    sens1_s5  <= sens1_s4;
    off2_s5   <= off2_next;
    sens2_s5  <= sens2_next;
    temp_s5   <= temp_s4;

    d1_s6     <= d1_s5;
    off_s6    <= off_next;
    sens_s6   <= sens_next;
    temp_s6   <= temp_s5;

    pp_lo_s7  <= pp_lo_next;
    pp_hi_s7  <= pp_hi_next;
    off_s7    <= off_s6;
    temp_s7   <= temp_s6;

    prod_s8   <= prod_next;
    off_s8    <= off_s7;
    temp_s8   <= temp_s7;

    a_s9      <= prod_rnd[60:21];
    off_s9    <= off_s8;
    temp_s9   <= temp_s8;

    b_s10     <= b_next;
    temp_s10  <= temp_s9;

    result.temperature_centi <= temp_s10;
    result.pressure_value    <= {{(PRES_W-26){pres_next[25]}}, pres_next};
  end

endmodule
